[rtl/assert_macros.svh]
// assertion macros used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked property, muted while the given active-low reset is asserted
`define ASSERT_RST(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// checked property with no reset qualification
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

[rtl/fsp_pkg.sv]
// types and constants for the four-step phase extractor
`default_nettype none

package fsp_pkg;

	localparam int CORDIC_STEPS = 32;
	localparam int PRE_SHIFT    = 24;
	localparam int Z_BITS       = 32;
	localparam int PHASE_BITS   = 16;

	localparam logic [Z_BITS-1:0] HALF_PI_Q30 = 32'd1686629713;

	// atan(2^-i) in q30, truncated
	localparam logic [Z_BITS-1:0] ATAN_Q30 [0:CORDIC_STEPS-1] = '{
		32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6,
		32'h03FEAB76, 32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55,
		32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF,
		32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF,
		32'h00003FFF, 32'h00001FFF, 32'h00000FFF, 32'h000007FF,
		32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F,
		32'h0000003F, 32'h0000001F, 32'h0000000F, 32'h00000008,
		32'h00000004, 32'h00000002, 32'h00000001, 32'h00000000
	};

	typedef struct packed {
		logic neg;
		logic n_zero;
		logic d_zero;
	} lane_flags_t;

	typedef struct packed {
		logic signed [Z_BITS-1:0] z;
		lane_flags_t              flags;
	} lane_res_t;

endpackage

`default_nettype wire

[rtl/fsp_cordic_stage.sv]
// one registered vectoring-mode cordic iteration
`default_nettype none

module fsp_cordic_stage import fsp_pkg::*; #(
	parameter int W   = 35,
	parameter int IDX = 0
) (
	input  wire logic                    clk,
	input  wire logic                    en,
	input  wire logic signed [W-1:0]     x,
	input  wire logic signed [W-1:0]     y,
	input  wire logic signed [Z_BITS-1:0] z,
	input  wire lane_flags_t             flags,
	output logic signed [W-1:0]          x_s1,
	output logic signed [W-1:0]          y_s1,
	output logic signed [Z_BITS-1:0]     z_s1,
	output lane_flags_t                  flags_s1
);

	localparam logic signed [Z_BITS-1:0] ANGLE = signed'(ATAN_Q30[IDX]);

	logic signed [W-1:0] xs;
	logic signed [W-1:0] ys;

	// floor shifts
	assign xs = x >>> IDX;
	assign ys = y >>> IDX;

	always_ff @(posedge clk) begin
		if (en) begin
			if (!y[W-1]) begin
				x_s1 <= x + ys;
				y_s1 <= y - xs;
				z_s1 <= z + ANGLE;
			end else begin
				x_s1 <= x - ys;
				y_s1 <= y + xs;
				z_s1 <= z - ANGLE;
			end
			flags_s1 <= flags;
		end
	end

endmodule

`default_nettype wire

[rtl/fsp_lane.sv]
// one direction: differences, magnitudes and the cordic pipeline
`default_nettype none

module fsp_lane import fsp_pkg::*; #(
	parameter int PIXEL_BITS = 8
) (
	input  wire logic                  clk,
	input  wire logic                  en,
	input  wire logic [PIXEL_BITS-1:0] shift0,
	input  wire logic [PIXEL_BITS-1:0] shift1,
	input  wire logic [PIXEL_BITS-1:0] shift2,
	input  wire logic [PIXEL_BITS-1:0] shift3,
	output lane_res_t                  res
);

	localparam int W = PIXEL_BITS + PRE_SHIFT + 3;

	logic signed [PIXEL_BITS:0] n;
	logic signed [PIXEL_BITS:0] d;
	logic [PIXEL_BITS:0]        an_full;
	logic [PIXEL_BITS:0]        ad_full;
	logic [PIXEL_BITS-1:0]      an;
	logic [PIXEL_BITS-1:0]      ad;

	logic signed [W-1:0]      x_c [0:CORDIC_STEPS];
	logic signed [W-1:0]      y_c [0:CORDIC_STEPS];
	logic signed [Z_BITS-1:0] z_c [0:CORDIC_STEPS];
	lane_flags_t              f_c [0:CORDIC_STEPS];

	assign n = signed'({1'b0, shift3}) - signed'({1'b0, shift1});
	assign d = signed'({1'b0, shift0}) - signed'({1'b0, shift2});
	assign an_full = n[PIXEL_BITS] ? unsigned'(-n) : unsigned'(n);
	assign ad_full = d[PIXEL_BITS] ? unsigned'(-d) : unsigned'(d);
	assign an = an_full[PIXEL_BITS-1:0];
	assign ad = ad_full[PIXEL_BITS-1:0];

	// entry register: scaled magnitudes and case flags
	always_ff @(posedge clk) begin
		if (en) begin
			x_c[0] <= signed'({3'b000, ad, {PRE_SHIFT{1'b0}}});
			y_c[0] <= signed'({3'b000, an, {PRE_SHIFT{1'b0}}});
			z_c[0] <= '0;
			f_c[0].neg    <= n[PIXEL_BITS] ^ d[PIXEL_BITS];
			f_c[0].n_zero <= (an == '0);
			f_c[0].d_zero <= (ad == '0);
		end
	end

	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
		fsp_cordic_stage #(
			.W   (W),
			.IDX (i)
		) u_stage (
			.clk      (clk),
			.en       (en),
			.x        (x_c[i]),
			.y        (y_c[i]),
			.z        (z_c[i]),
			.flags    (f_c[i]),
			.x_s1     (x_c[i+1]),
			.y_s1     (y_c[i+1]),
			.z_s1     (z_c[i+1]),
			.flags_s1 (f_c[i+1])
		);
	end

	assign res.z     = z_c[CORDIC_STEPS];
	assign res.flags = f_c[CORDIC_STEPS];

endmodule

`default_nettype wire

[rtl/fsp_merge.sv]
// clamp, round, sign and saturate both lanes into the result register
`default_nettype none

module fsp_merge import fsp_pkg::*; #(
	parameter int PHASE_FRAC_BITS = 14
) (
	input  wire logic                   clk,
	input  wire logic                   en,
	input  wire lane_res_t              res_h,
	input  wire lane_res_t              res_v,
	output logic signed [PHASE_BITS-1:0] phase_h_q,
	output logic signed [PHASE_BITS-1:0] phase_v_q,
	output logic                        undef_h_q,
	output logic                        undef_v_q
);

	localparam int          RND_SHIFT = 30 - PHASE_FRAC_BITS;
	localparam logic [32:0] HALF_LSB  = (RND_SHIFT == 0) ? 33'd0 : (33'd1 << (RND_SHIFT - 1));
	localparam logic signed [32:0] PMAX = 33'sd32767;
	localparam logic signed [32:0] PMIN = -33'sd32768;

	function automatic logic signed [PHASE_BITS-1:0] finish(lane_res_t r);
		logic [32:0]        zc;
		logic [32:0]        rnd;
		logic signed [32:0] p;
		// clamp to 0 .. pi/2, vertical case takes pi/2 directly
		if (r.flags.d_zero)
			zc = {1'b0, HALF_PI_Q30};
		else if (r.z < 0)
			zc = '0;
		else if (r.z > signed'({1'b0, HALF_PI_Q30[Z_BITS-2:0]}))
			zc = {1'b0, HALF_PI_Q30};
		else
			zc = {1'b0, r.z};
		rnd = (zc + HALF_LSB) >> RND_SHIFT;
		if (r.flags.n_zero)
			p = '0;
		else if (r.flags.neg)
			p = -signed'(rnd);
		else
			p = signed'(rnd);
		if (p > PMAX)
			p = PMAX;
		else if (p < PMIN)
			p = PMIN;
		return p[PHASE_BITS-1:0];
	endfunction

	always_ff @(posedge clk) begin
		if (en) begin
			phase_h_q <= finish(res_h);
			phase_v_q <= finish(res_v);
			undef_h_q <= res_h.flags.n_zero & res_h.flags.d_zero;
			undef_v_q <= res_v.flags.n_zero & res_v.flags.d_zero;
		end
	end

endmodule

`default_nettype wire

[rtl/four_step_phase_extract.sv]
// top level of the four-step wrapped phase extractor
//
// channel  dir  handshake            payload
// in       in   in_valid / in_stall  h_shift0..3, v_shift0..3
// out      out  out_valid / out_stall phase_h, phase_v, undefined_h, undefined_v
//
// one request per cycle while not stalled; registers in order: entry register, 32 cordic stages
// per lane, one result register after the merge
// the whole pipeline advances together; it freezes only while a result waits
// in the output register under out_stall, and in_stall follows that
// reset clears the valid line and the output valid; payload is not reset
`default_nettype none

module four_step_phase_extract import fsp_pkg::*; #(
	parameter int PIXEL_BITS      = 8,
	parameter int PHASE_FRAC_BITS = 14
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    in_valid,
	output logic                         in_stall,
	input  wire logic [PIXEL_BITS-1:0]   h_shift0,
	input  wire logic [PIXEL_BITS-1:0]   h_shift1,
	input  wire logic [PIXEL_BITS-1:0]   h_shift2,
	input  wire logic [PIXEL_BITS-1:0]   h_shift3,
	input  wire logic [PIXEL_BITS-1:0]   v_shift0,
	input  wire logic [PIXEL_BITS-1:0]   v_shift1,
	input  wire logic [PIXEL_BITS-1:0]   v_shift2,
	input  wire logic [PIXEL_BITS-1:0]   v_shift3,
	output logic                         out_valid,
	input  wire logic                    out_stall,
	output logic signed [PHASE_BITS-1:0] phase_h,
	output logic signed [PHASE_BITS-1:0] phase_v,
	output logic                         undefined_h,
	output logic                         undefined_v
);

`include "assert_macros.svh"

	// entry register plus one per cordic step
	localparam int LANE_DEPTH = CORDIC_STEPS + 1;

	logic                  en;
	logic [LANE_DEPTH-1:0] vld_q;
	logic                  out_valid_q;
	lane_res_t             res_h;
	lane_res_t             res_v;

	// advance unless a finished result is held back
	assign en       = !out_valid_q || !out_stall;
	assign in_stall = !en;

	// valid line that shadows the lane pipelines
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q       <= '0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			vld_q       <= {vld_q[LANE_DEPTH-2:0], in_valid};
			out_valid_q <= vld_q[LANE_DEPTH-1];
		end
	end

	// horizontal lane
	fsp_lane #(
		.PIXEL_BITS (PIXEL_BITS)
	) u_lane_h (
		.clk    (clk),
		.en     (en),
		.shift0 (h_shift0),
		.shift1 (h_shift1),
		.shift2 (h_shift2),
		.shift3 (h_shift3),
		.res    (res_h)
	);

	// vertical lane
	fsp_lane #(
		.PIXEL_BITS (PIXEL_BITS)
	) u_lane_v (
		.clk    (clk),
		.en     (en),
		.shift0 (v_shift0),
		.shift1 (v_shift1),
		.shift2 (v_shift2),
		.shift3 (v_shift3),
		.res    (res_v)
	);

	// both lanes meet in the result register
	fsp_merge #(
		.PHASE_FRAC_BITS (PHASE_FRAC_BITS)
	) u_merge (
		.clk       (clk),
		.en        (en),
		.res_h     (res_h),
		.res_v     (res_v),
		.phase_h_q (phase_h),
		.phase_v_q (phase_v),
		.undef_h_q (undefined_h),
		.undef_v_q (undefined_v)
	);

	assign out_valid = out_valid_q;

	// an undefined pixel carries a zero phase
	`ASSERT_RST(a_undef_h_zero, clk, arst_n, out_valid && undefined_h |-> phase_h == '0, "undefined h phase not zero")
	`ASSERT_RST(a_undef_v_zero, clk, arst_n, out_valid && undefined_v |-> phase_v == '0, "undefined v phase not zero")
	// a frozen pipeline keeps its requests in place
	`ASSERT_RST(a_freeze_holds, clk, arst_n, in_stall |=> $stable(vld_q), "valid line moved while stalled")
	// in reset nothing is offered downstream
	`ASSERT_ALWAYS(a_reset_quiet, clk, !arst_n |-> !out_valid, "output valid during reset")

endmodule

`default_nettype wire
